[rtl/biq_pkg.sv]
// shared widths, register indices, mode codes and types for the biquad filter
// no dependencies; imported by every other file of the block
package biq_pkg;

	// sample and coefficient formats
	localparam int SAMPLE_WIDTH   = 16;
	localparam int COEF_WIDTH     = 18;
	localparam int COEF_FRAC_BITS = 14;

	// product and accumulator widths (five products, three guard bits)
	localparam int PROD_WIDTH = SAMPLE_WIDTH + COEF_WIDTH;
	localparam int ACC_WIDTH  = PROD_WIDTH + 3;

	// configuration port
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH  = COEF_WIDTH;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODE = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_B0   = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_B1   = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_B2   = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_A1   = 3'd4;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_A2   = 3'd5;

	// filter modes; the unused code behaves as bypass
	localparam int MODE_WIDTH = 2;
	localparam logic [MODE_WIDTH-1:0] MODE_BYPASS = 2'd0;
	localparam logic [MODE_WIDTH-1:0] MODE_FIRST  = 2'd1;
	localparam logic [MODE_WIDTH-1:0] MODE_BIQUAD = 2'd2;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [COEF_WIDTH-1:0]   coef_t;

	// coefficient set as held by the register bank
	typedef struct packed {
		coef_t b0;
		coef_t b1;
		coef_t b2;
		coef_t a1;
		coef_t a2;
	} biq_coefs_t;

	// pipeline control from the top level to the datapath
	typedef struct packed {
		logic load_s1;
		logic step_s1;
	} biq_ctrl_t;

endpackage

[rtl/biq_sample_if.sv]
// input sample channel: valid/ready handshake carrying one sample word
// depends on biq_pkg
interface biq_sample_if
	import biq_pkg::*;
();
	logic    valid;
	logic    ready;
	sample_t sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

[rtl/biq_result_if.sv]
// result channel: valid/ready handshake carrying the filtered word and clip flag
// depends on biq_pkg
interface biq_result_if
	import biq_pkg::*;
();
	logic    valid;
	logic    ready;
	sample_t sample_out;
	logic    clipped;

	modport source (output valid, output sample_out, output clipped, input ready);
	modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

[rtl/biq_cfg_if.sv]
// configuration write channel: valid/ready with register index and data
// depends on biq_pkg
interface biq_cfg_if
	import biq_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [CFG_DATA_WIDTH-1:0]  cfg_data;

	modport source (output valid, output cfg_index, output cfg_data, input ready);
	modport sink (input valid, input cfg_index, input cfg_data, output ready);
endinterface

[rtl/biq_cfg_regs.sv]
// configuration register bank: filter mode and the five coefficients
// depends on biq_pkg and biq_cfg_if
module biq_cfg_regs
	import biq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	biq_cfg_if.sink            cfg,
	output logic [MODE_WIDTH-1:0] mode,
	output biq_coefs_t         coefs
);

	logic [MODE_WIDTH-1:0] mode_q;
	biq_coefs_t            coefs_q;
	logic                  wr_en;

	// writes are always taken
	assign cfg.ready = 1'b1;
	assign wr_en     = cfg.valid & cfg.ready;

	// register write decode; indices past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_BYPASS;
			coefs_q <= '0;
		end else if (wr_en) begin
			unique case (cfg.cfg_index)
				REG_MODE: mode_q     <= cfg.cfg_data[MODE_WIDTH-1:0];
				REG_B0:   coefs_q.b0 <= cfg.cfg_data;
				REG_B1:   coefs_q.b1 <= cfg.cfg_data;
				REG_B2:   coefs_q.b2 <= cfg.cfg_data;
				REG_A1:   coefs_q.a1 <= cfg.cfg_data;
				REG_A2:   coefs_q.a2 <= cfg.cfg_data;
				default: ;
			endcase
		end
	end

	assign mode  = mode_q;
	assign coefs = coefs_q;

endmodule

[rtl/biq_datapath.sv]
// sample register, five multipliers, rounding and saturation, history and
// result register; depends on biq_pkg
module biq_datapath
	import biq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  biq_ctrl_t             ctrl,
	input  sample_t               sample_in,
	input  logic [MODE_WIDTH-1:0] mode,
	input  biq_coefs_t            coefs,
	output sample_t               sample_out,
	output logic                  clipped
);

	localparam logic signed [ACC_WIDTH-1:0] RND_HALF =
		ACC_WIDTH'(64'sd1 <<< (COEF_FRAC_BITS - 1));

	sample_t x_s1;
	sample_t y_s2;
	logic    clip_s2;

	// history: two inputs and two saturated outputs
	sample_t in_d1_q, in_d2_q, out_d1_q, out_d2_q;

	logic signed [PROD_WIDTH-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
	logic signed [ACC_WIDTH-1:0]  acc, acc_rnd, rnd;
	sample_t                      y_sat;
	logic                         clip_sat;
	sample_t                      y_next;
	logic                         clip_next;

	function automatic logic signed [ACC_WIDTH-1:0] ext(logic signed [PROD_WIDTH-1:0] p);
		return {{(ACC_WIDTH-PROD_WIDTH){p[PROD_WIDTH-1]}}, p};
	endfunction

	// input sample register
	always_ff @(posedge clk) begin
		if (ctrl.load_s1)
			x_s1 <= sample_in;
	end

	// the five products
	always_comb begin
		p_b0 = PROD_WIDTH'(coefs.b0) * PROD_WIDTH'(x_s1);
		p_b1 = PROD_WIDTH'(coefs.b1) * PROD_WIDTH'(in_d1_q);
		p_b2 = PROD_WIDTH'(coefs.b2) * PROD_WIDTH'(in_d2_q);
		p_a1 = PROD_WIDTH'(coefs.a1) * PROD_WIDTH'(out_d1_q);
		p_a2 = PROD_WIDTH'(coefs.a2) * PROD_WIDTH'(out_d2_q);
	end

	// accumulate per mode
	always_comb begin
		case (mode)
			MODE_FIRST:  acc = ext(p_b0) + ext(p_a1);
			MODE_BIQUAD: acc = ext(p_b0) + ext(p_b1) + ext(p_b2) - ext(p_a1) - ext(p_a2);
			default:     acc = '0;
		endcase
	end

	// round half up to sample scale, then saturate
	always_comb begin
		acc_rnd = acc + RND_HALF;
		rnd     = acc_rnd >>> COEF_FRAC_BITS;
		if (rnd[ACC_WIDTH-1:SAMPLE_WIDTH-1] == '0 || rnd[ACC_WIDTH-1:SAMPLE_WIDTH-1] == '1) begin
			y_sat    = rnd[SAMPLE_WIDTH-1:0];
			clip_sat = 1'b0;
		end else begin
			y_sat    = rnd[ACC_WIDTH-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
			                            : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
			clip_sat = 1'b1;
		end
	end

	// bypass and the unused mode pass the sample through
	always_comb begin
		if (mode == MODE_FIRST || mode == MODE_BIQUAD) begin
			y_next    = y_sat;
			clip_next = clip_sat;
		end else begin
			y_next    = x_s1;
			clip_next = 1'b0;
		end
	end

	// history update as the word leaves stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_d1_q  <= '0;
			in_d2_q  <= '0;
			out_d1_q <= '0;
			out_d2_q <= '0;
		end else if (ctrl.step_s1) begin
			if (mode == MODE_FIRST) begin
				out_d1_q <= y_sat;
			end else if (mode == MODE_BIQUAD) begin
				in_d1_q  <= x_s1;
				in_d2_q  <= in_d1_q;
				out_d1_q <= y_sat;
				out_d2_q <= out_d1_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctrl.step_s1) begin
			y_s2    <= y_next;
			clip_s2 <= clip_next;
		end
	end

	assign sample_out = y_s2;
	assign clipped    = clip_s2;

endmodule

[rtl/biquad_iir_filter_unit.sv]
// Biquad / first-order IIR filter on signed 16-bit samples.
// Channels: samples (sink) takes one sample word, results (source) gives the
// filtered word with a clip flag, cfg (sink) writes the mode register (index
// 0) and the Q4.14 coefficients b0, b1, b2, a1, a2 (indices 1 to 5).
// Each accepted word produces exactly one result word, in order.
// An accepted word passes the input register and then the result register
// before it is on results. Throughput: one word per cycle while results does
// not stall; the feedback path (five multiplies, sum, round, saturate) is
// combinational between the sample register and the history registers.
// When results stalls, the result register holds and one more word can still
// be taken into the input register; samples.ready then drops until the
// result is taken. cfg is always ready and should be written only while no
// word is in flight.
// Reset clears the mode to bypass, all coefficients and the sample/output
// history to zero, and empties both pipeline stages.
// Depends on biq_pkg, the three channel interfaces, biq_cfg_regs, biq_datapath.
module biquad_iir_filter_unit
	import biq_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	biq_sample_if.sink   samples,
	biq_result_if.source results,
	biq_cfg_if.sink      cfg
);

	logic                  valid_s1;
	logic                  valid_s2;
	logic                  advance;
	biq_ctrl_t             ctrl;
	logic [MODE_WIDTH-1:0] mode;
	biq_coefs_t            coefs;

	// pipeline flow: stage two frees when taken, stage one when it can move
	assign advance         = !valid_s2 || results.ready;
	assign samples.ready   = !valid_s1 || advance;
	assign ctrl.load_s1    = samples.valid && samples.ready;
	assign ctrl.step_s1    = valid_s1 && advance;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (samples.ready)
				valid_s1 <= samples.valid;
			if (advance)
				valid_s2 <= valid_s1;
		end
	end

	biq_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.mode   (mode),
		.coefs  (coefs)
	);

	biq_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.sample_in  (samples.sample_in),
		.mode       (mode),
		.coefs      (coefs),
		.sample_out (results.sample_out),
		.clipped    (results.clipped)
	);

	assign results.valid = valid_s2;

	// a new result only appears after stage one stepped
	a_result_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(ctrl.step_s1))
		else $error("result appeared without a stage one step");

	// a stalled result blocks stage one from moving
	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !results.ready) |-> !ctrl.step_s1)
		else $error("stage one stepped into a stalled result register");

	// an empty input stage always takes a word
	a_empty_s1_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> samples.ready)
		else $error("input stage empty but not ready");

	// a word held in stage one under stall stays there
	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("stage one word lost during stall");

endmodule
